>>> hdl/msr_pkg.sv
// msr_pkg: request/response payload types, status codes and sequencer states
// for the modular square root block. No dependencies.
package msr_pkg;

   typedef struct packed {
      logic [63:0] value;
      logic [63:0] modulus;
   } req_type;

   typedef struct packed {
      logic [63:0] root_first;
      logic [63:0] root_second;
      logic [1:0]  root_count;
      logic [1:0]  status;
   } rsp_type;

   localparam logic [1:0] ST_FOUND     = 2'd0;
   localparam logic [1:0] ST_NONRES    = 2'd1;
   localparam logic [1:0] ST_BADMOD    = 2'd2;
   localparam logic [1:0] ST_EXHAUSTED = 2'd3;

   // Euler criterion classes: result 0, 1, p-1, anything else
   localparam logic [1:0] EC_ZERO  = 2'd0;
   localparam logic [1:0] EC_ONE   = 2'd1;
   localparam logic [1:0] EC_MINUS = 2'd2;
   localparam logic [1:0] EC_OTHER = 2'd3;

   localparam logic [1:0] CNT_NONE = 2'd0;
   localparam logic [1:0] CNT_ONE  = 2'd1;
   localparam logic [1:0] CNT_TWO  = 2'd2;

   typedef enum logic [29:0] {
      S_IDLE    = 30'd1 << 0,
      S_REDA    = 30'd1 << 1,
      S_EU_INIT = 30'd1 << 2,
      S_EU_TEST = 30'd1 << 3,
      S_EU_MR   = 30'd1 << 4,
      S_EU_SQ   = 30'd1 << 5,
      S_EU_DONE = 30'd1 << 6,
      S_T_SQ    = 30'd1 << 7,
      S_T_W     = 30'd1 << 8,
      S_T_NEXT  = 30'd1 << 9,
      S_X_INIT  = 30'd1 << 10,
      S_X_TEST  = 30'd1 << 11,
      S_X_M1    = 30'd1 << 12,
      S_X_M2    = 30'd1 << 13,
      S_X_M3    = 30'd1 << 14,
      S_X_A1    = 30'd1 << 15,
      S_X_M4    = 30'd1 << 16,
      S_X_M5    = 30'd1 << 17,
      S_X_A2    = 30'd1 << 18,
      S_X_S1    = 30'd1 << 19,
      S_X_S2    = 30'd1 << 20,
      S_X_S3    = 30'd1 << 21,
      S_X_A3    = 30'd1 << 22,
      S_X_S4    = 30'd1 << 23,
      S_V_SQ1   = 30'd1 << 24,
      S_V_SQ2   = 30'd1 << 25,
      S_V_DEC   = 30'd1 << 26,
      S_FIN     = 30'd1 << 27,
      S_SPARE0  = 30'd1 << 28,
      S_SPARE1  = 30'd1 << 29
   } state_type;

endpackage

>>> hdl/modular_square_root.sv
// Cost: every modular multiply runs on the one shared serial multiplier;
// a request costs up to about (2*WIDTH + MAX_TRIES*(11*WIDTH + 3)) multiplies.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: synchronous, active high; clears the sequencer and the response valid.
// Uses msr_pkg (payload types, codes, states) and msr_modmul.
module modular_square_root #(
   parameter int WIDTH     = 64,
   parameter int MAX_TRIES = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  msr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output msr_pkg::rsp_type rsp_data
);

   localparam int TW = $clog2(MAX_TRIES + 1);

   // add modulo m, operands below m
   function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                                input logic [WIDTH-1:0] b,
                                                input logic [WIDTH-1:0] m);
      logic [WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[WIDTH-1:0];
   endfunction

   msr_pkg::state_type state_ff, state_in;

   logic [WIDTH-1:0] p_ff, p_in;     // modulus
   logic [WIDTH-1:0] v_ff, v_in;     // raw value
   logic [WIDTH-1:0] a_ff, a_in;     // value mod p
   logic [WIDTH-1:0] w_ff, w_in;     // omega
   logic [WIDTH-1:0] r_ff, r_in;     // Euler accumulator
   logic [WIDTH-1:0] b_ff, b_in;     // Euler base
   logic [WIDTH-1:0] e_ff, e_in;     // exponent shift register
   logic [WIDTH-1:0] tm_ff, tm_in;   // t mod p
   logic [TW-1:0]    t_ff, t_in;     // try count
   logic [WIDTH-1:0] rr_ff, rr_in;
   logic [WIDTH-1:0] ri_ff, ri_in;
   logic [WIDTH-1:0] br_ff, br_in;
   logic [WIDTH-1:0] bi_ff, bi_in;
   logic [WIDTH-1:0] t1_ff, t1_in;
   logic [WIDTH-1:0] t2_ff, t2_in;
   logic [WIDTH-1:0] t3_ff, t3_in;
   logic             ok1_ff, ok1_in;
   logic             ok2_ff, ok2_in;
   logic             eusel_ff, eusel_in;  // 0: value, 1: omega
   logic             pend_ff, pend_in;    // multiply in flight
   msr_pkg::rsp_type res_ff, res_in;
   msr_pkg::rsp_type rspd_ff, rspd_in;
   logic             rspv_ff, rspv_in;

   logic             mul_start, mul_done;
   logic [WIDTH-1:0] mul_x, mul_y, mul_res;
   logic [WIDTH-1:0] x2;
   logic [WIDTH-1:0] pin;
   logic [1:0]       eclass;

   msr_modmul #(.WIDTH(WIDTH)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .x      (mul_x),
      .y      (mul_y),
      .m      (p_ff),
      .done   (mul_done),
      .result (mul_res)
   );

   assign pin = req_data.modulus[WIDTH-1:0];
   assign x2  = (rr_ff == '0) ? '0 : p_ff - rr_ff;

   always_comb begin
      if (r_ff == '0) begin
         eclass = msr_pkg::EC_ZERO;
      end else if (r_ff == WIDTH'(1)) begin
         eclass = msr_pkg::EC_ONE;
      end else if (r_ff == p_ff - WIDTH'(1)) begin
         eclass = msr_pkg::EC_MINUS;
      end else begin
         eclass = msr_pkg::EC_OTHER;
      end
   end

   // multiplier operand select
   always_comb begin
      mul_x = '0;
      mul_y = '0;
      unique case (state_ff)
         msr_pkg::S_REDA:  begin mul_x = WIDTH'(1); mul_y = v_ff;  end
         msr_pkg::S_EU_MR: begin mul_x = r_ff;      mul_y = b_ff;  end
         msr_pkg::S_EU_SQ: begin mul_x = b_ff;      mul_y = b_ff;  end
         msr_pkg::S_T_SQ:  begin mul_x = tm_ff;     mul_y = tm_ff; end
         msr_pkg::S_X_M1:  begin mul_x = rr_ff;     mul_y = br_ff; end
         msr_pkg::S_X_M2:  begin mul_x = ri_ff;     mul_y = bi_ff; end
         msr_pkg::S_X_M3:  begin mul_x = t2_ff;     mul_y = w_ff;  end
         msr_pkg::S_X_M4:  begin mul_x = rr_ff;     mul_y = bi_ff; end
         msr_pkg::S_X_M5:  begin mul_x = ri_ff;     mul_y = br_ff; end
         msr_pkg::S_X_S1:  begin mul_x = br_ff;     mul_y = br_ff; end
         msr_pkg::S_X_S2:  begin mul_x = bi_ff;     mul_y = bi_ff; end
         msr_pkg::S_X_S3:  begin mul_x = t2_ff;     mul_y = w_ff;  end
         msr_pkg::S_X_S4:  begin mul_x = t3_ff;     mul_y = bi_ff; end
         msr_pkg::S_V_SQ1: begin mul_x = rr_ff;     mul_y = rr_ff; end
         msr_pkg::S_V_SQ2: begin mul_x = x2;        mul_y = x2;    end
         default:          begin mul_x = '0;        mul_y = '0;    end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      p_in      = p_ff;
      v_in      = v_ff;
      a_in      = a_ff;
      w_in      = w_ff;
      r_in      = r_ff;
      b_in      = b_ff;
      e_in      = e_ff;
      tm_in     = tm_ff;
      t_in      = t_ff;
      rr_in     = rr_ff;
      ri_in     = ri_ff;
      br_in     = br_ff;
      bi_in     = bi_ff;
      t1_in     = t1_ff;
      t2_in     = t2_ff;
      t3_in     = t3_ff;
      ok1_in    = ok1_ff;
      ok2_in    = ok2_ff;
      eusel_in  = eusel_ff;
      pend_in   = pend_ff;
      res_in    = res_ff;
      mul_start = 1'b0;
      req_ready = 1'b0;

      unique case (state_ff)
         msr_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               p_in = pin;
               v_in = req_data.value[WIDTH-1:0];
               if (pin <= WIDTH'(2)) begin
                  res_in   = '{64'd0, 64'd0, msr_pkg::CNT_NONE, msr_pkg::ST_BADMOD};
                  state_in = msr_pkg::S_FIN;
               end else begin
                  state_in = msr_pkg::S_REDA;
               end
            end
         end
         // value mod p as 1 * value on the serial multiplier
         msr_pkg::S_REDA: begin
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_done) begin
               pend_in = 1'b0;
               a_in    = mul_res;
               if (mul_res == '0) begin
                  res_in   = '{64'd0, 64'd0, msr_pkg::CNT_ONE, msr_pkg::ST_FOUND};
                  state_in = msr_pkg::S_FIN;
               end else begin
                  eusel_in = 1'b0;
                  state_in = msr_pkg::S_EU_INIT;
               end
            end
         end
         msr_pkg::S_EU_INIT: begin
            r_in     = WIDTH'(1);
            b_in     = eusel_ff ? w_ff : a_ff;
            e_in     = (p_ff - WIDTH'(1)) >> 1;
            state_in = msr_pkg::S_EU_TEST;
         end
         msr_pkg::S_EU_TEST: begin
            if (e_ff == '0) begin
               state_in = msr_pkg::S_EU_DONE;
            end else if (e_ff[0]) begin
               state_in = msr_pkg::S_EU_MR;
            end else begin
               state_in = msr_pkg::S_EU_SQ;
            end
         end
         msr_pkg::S_EU_MR: begin
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_done) begin
               pend_in  = 1'b0;
               r_in     = mul_res;
               state_in = msr_pkg::S_EU_SQ;
            end
         end
         msr_pkg::S_EU_SQ: begin
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_done) begin
               pend_in  = 1'b0;
               b_in     = mul_res;
               e_in     = e_ff >> 1;
               state_in = msr_pkg::S_EU_TEST;
            end
         end
         msr_pkg::S_EU_DONE: begin
            if (eclass == msr_pkg::EC_OTHER) begin
               res_in   = '{64'd0, 64'd0, msr_pkg::CNT_NONE, msr_pkg::ST_BADMOD};
               state_in = msr_pkg::S_FIN;
            end else if (!eusel_ff) begin
               if (eclass != msr_pkg::EC_ONE) begin
                  res_in   = '{64'd0, 64'd0, msr_pkg::CNT_NONE, msr_pkg::ST_NONRES};
                  state_in = msr_pkg::S_FIN;
               end else begin
                  t_in     = TW'(1);
                  tm_in    = WIDTH'(1);
                  state_in = msr_pkg::S_T_SQ;
               end
            end else if (eclass == msr_pkg::EC_MINUS) begin
               state_in = msr_pkg::S_X_INIT;
            end else begin
               state_in = msr_pkg::S_T_NEXT;
            end
         end
         msr_pkg::S_T_SQ: begin
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_done) begin
               pend_in  = 1'b0;
               t1_in    = mul_res;
               state_in = msr_pkg::S_T_W;
            end
         end
         // omega = t^2 - a; a is nonzero so p - a is already reduced
         msr_pkg::S_T_W: begin
            w_in = add_mod(t1_ff, p_ff - a_ff, p_ff);
            if (add_mod(t1_ff, p_ff - a_ff, p_ff) == '0) begin
               state_in = msr_pkg::S_T_NEXT;
            end else begin
               eusel_in = 1'b1;
               state_in = msr_pkg::S_EU_INIT;
            end
         end
         msr_pkg::S_T_NEXT: begin
            if (t_ff == TW'(MAX_TRIES)) begin
               res_in   = '{64'd0, 64'd0, msr_pkg::CNT_NONE, msr_pkg::ST_EXHAUSTED};
               state_in = msr_pkg::S_FIN;
            end else begin
               t_in     = t_ff + 1'b1;
               tm_in    = (tm_ff + WIDTH'(1) == p_ff) ? '0 : tm_ff + WIDTH'(1);
               state_in = msr_pkg::S_T_SQ;
            end
         end
         // (t + sqrt(w))^ceil(p/2) by square and multiply
         msr_pkg::S_X_INIT: begin
            rr_in    = WIDTH'(1);
            ri_in    = '0;
            br_in    = tm_ff;
            bi_in    = WIDTH'(1);
            e_in     = (p_ff >> 1) + WIDTH'(p_ff[0]);
            state_in = msr_pkg::S_X_TEST;
         end
         msr_pkg::S_X_TEST: begin
            if (e_ff == '0) begin
               state_in = msr_pkg::S_V_SQ1;
            end else if (e_ff[0]) begin
               state_in = msr_pkg::S_X_M1;
            end else begin
               state_in = msr_pkg::S_X_S1;
            end
         end
         msr_pkg::S_X_M1: begin
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_done) begin
               pend_in  = 1'b0;
               t1_in    = mul_res;
               state_in = msr_pkg::S_X_M2;
            end
         end
         msr_pkg::S_X_M2: begin
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_done) begin
               pend_in  = 1'b0;
               t2_in    = mul_res;
               state_in = msr_pkg::S_X_M3;
            end
         end
         msr_pkg::S_X_M3: begin
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_done) begin
               pend_in  = 1'b0;
               t2_in    = mul_res;
               state_in = msr_pkg::S_X_A1;
            end
         end
         msr_pkg::S_X_A1: begin
            t1_in    = add_mod(t1_ff, t2_ff, p_ff);
            state_in = msr_pkg::S_X_M4;
         end
         msr_pkg::S_X_M4: begin
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_done) begin
               pend_in  = 1'b0;
               t2_in    = mul_res;
               state_in = msr_pkg::S_X_M5;
            end
         end
         msr_pkg::S_X_M5: begin
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_done) begin
               pend_in  = 1'b0;
               t3_in    = mul_res;
               state_in = msr_pkg::S_X_A2;
            end
         end
         msr_pkg::S_X_A2: begin
            ri_in    = add_mod(t2_ff, t3_ff, p_ff);
            rr_in    = t1_ff;
            state_in = msr_pkg::S_X_S1;
         end
         msr_pkg::S_X_S1: begin
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_done) begin
               pend_in  = 1'b0;
               t1_in    = mul_res;
               state_in = msr_pkg::S_X_S2;
            end
         end
         msr_pkg::S_X_S2: begin
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_done) begin
               pend_in  = 1'b0;
               t2_in    = mul_res;
               state_in = msr_pkg::S_X_S3;
            end
         end
         msr_pkg::S_X_S3: begin
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_done) begin
               pend_in  = 1'b0;
               t2_in    = mul_res;
               state_in = msr_pkg::S_X_A3;
            end
         end
         msr_pkg::S_X_A3: begin
            t1_in    = add_mod(t1_ff, t2_ff, p_ff);
            t3_in    = add_mod(br_ff, br_ff, p_ff);
            state_in = msr_pkg::S_X_S4;
         end
         msr_pkg::S_X_S4: begin
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_done) begin
               pend_in  = 1'b0;
               bi_in    = mul_res;
               br_in    = t1_ff;
               e_in     = e_ff >> 1;
               state_in = msr_pkg::S_X_TEST;
            end
         end
         // check both candidates by squaring
         msr_pkg::S_V_SQ1: begin
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_done) begin
               pend_in  = 1'b0;
               ok1_in   = (mul_res == a_ff);
               state_in = msr_pkg::S_V_SQ2;
            end
         end
         msr_pkg::S_V_SQ2: begin
            mul_start = !pend_ff;
            pend_in   = 1'b1;
            if (mul_done) begin
               pend_in  = 1'b0;
               ok2_in   = (mul_res == a_ff) && (rr_ff != x2);
               state_in = msr_pkg::S_V_DEC;
            end
         end
         msr_pkg::S_V_DEC: begin
            if (ok1_ff && ok2_ff) begin
               res_in   = '{64'(rr_ff), 64'(x2), msr_pkg::CNT_TWO, msr_pkg::ST_FOUND};
               state_in = msr_pkg::S_FIN;
            end else if (ok1_ff) begin
               res_in   = '{64'(rr_ff), 64'd0, msr_pkg::CNT_ONE, msr_pkg::ST_FOUND};
               state_in = msr_pkg::S_FIN;
            end else if (ok2_ff) begin
               res_in   = '{64'(x2), 64'd0, msr_pkg::CNT_ONE, msr_pkg::ST_FOUND};
               state_in = msr_pkg::S_FIN;
            end else begin
               state_in = msr_pkg::S_T_NEXT;
            end
         end
         // hand off to the response register once it is free
         msr_pkg::S_FIN: begin
            if (!rspv_ff || rsp_ready) begin
               state_in = msr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = msr_pkg::S_IDLE;
            pend_in  = 1'b0;
         end
      endcase
   end

   // response register: loaded from S_FIN, held until taken
   always_comb begin
      rspv_in = rspv_ff;
      rspd_in = rspd_ff;
      if (rspv_ff && rsp_ready) begin
         rspv_in = 1'b0;
      end
      if ((state_ff == msr_pkg::S_FIN) && (!rspv_ff || rsp_ready)) begin
         rspv_in = 1'b1;
         rspd_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      v_ff    <= v_in;
      a_ff    <= a_in;
      w_ff    <= w_in;
      r_ff    <= r_in;
      b_ff    <= b_in;
      e_ff    <= e_in;
      tm_ff   <= tm_in;
      t_ff    <= t_in;
      rr_ff   <= rr_in;
      ri_ff   <= ri_in;
      br_ff   <= br_in;
      bi_ff   <= bi_in;
      t1_ff   <= t1_in;
      t2_ff   <= t2_in;
      t3_ff   <= t3_in;
      ok1_ff  <= ok1_in;
      ok2_ff  <= ok2_in;
      eusel_ff <= eusel_in;
      res_ff  <= res_in;
      rspd_ff <= rspd_in;
      if (reset) begin
         state_ff <= msr_pkg::S_IDLE;
         pend_ff  <= 1'b0;
         rspv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         rspv_ff  <= rspv_in;
      end
   end

   assign rsp_valid = rspv_ff;
   assign rsp_data  = rspd_ff;

endmodule

>>> hdl/msr_modmul.sv
// msr_modmul: bit-serial modular multiplier, one multiplier bit per cycle,
// MSB first, with the accumulator kept below the modulus. Uses no package.
module msr_modmul #(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] x,
   input  logic [WIDTH-1:0] y,
   input  logic [WIDTH-1:0] m,
   output logic             done,
   output logic [WIDTH-1:0] result
);

   localparam int CW = $clog2(WIDTH);

   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] x_ff, x_in;
   logic [WIDTH-1:0] y_ff, y_in;
   logic [WIDTH-1:0] m_ff, m_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH+1:0] sum, m1, m2, red;

   // 2*acc + bit*x stays below 3m: subtract m or 2m
   always_comb begin
      sum = {1'b0, acc_ff, 1'b0} + (y_ff[WIDTH-1] ? {2'b00, x_ff} : '0);
      m1  = {2'b00, m_ff};
      m2  = {1'b0, m_ff, 1'b0};
      if (sum >= m2) begin
         red = sum - m2;
      end else if (sum >= m1) begin
         red = sum - m1;
      end else begin
         red = sum;
      end
   end

   always_comb begin
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      m_in    = m_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         x_in    = x;
         y_in    = y;
         m_in    = m;
         cnt_in  = CW'(WIDTH - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = red[WIDTH-1:0];
         y_in   = {y_ff[WIDTH-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      m_ff   <= m_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

>>> hdl/msr_checker.sv
// msr_checker: port-level assertions for modular_square_root, bound to the top.
// Depends on msr_pkg for payload types and codes.
module msr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input msr_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input msr_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in work");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.root_count != 2'd3)
      else $error("root count out of range");

   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != msr_pkg::ST_FOUND) |->
      rsp_data.root_count == msr_pkg::CNT_NONE && rsp_data.root_first == 64'd0 &&
      rsp_data.root_second == 64'd0)
      else $error("failed request reports roots");

   a_second_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.root_count != msr_pkg::CNT_TWO) |->
      rsp_data.root_second == 64'd0)
      else $error("second root set without two roots");

endmodule

bind modular_square_root msr_checker u_msr_checker (.*);

>>> dv/msr_checker.sv
// msr_scoreboard: watches the request and response channels of modular_square_root,
// predicts each response with its own Cipolla root search and compares. Uses msr_pkg.
module msr_scoreboard (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  msr_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  msr_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending,
   output int               found_count,
   output int               nonres_count,
   output int               badmod_count,
   output int               exhausted_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TRY_LIMIT = 10;

   msr_pkg::rsp_type roots_due[$];

   function automatic logic [63:0] add_m(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[63:0];
   endfunction

   function automatic logic [63:0] mul_m(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return 64'(prod % {64'd0, m});
   endfunction

   function automatic logic [63:0] pow_m(logic [63:0] b, logic [63:0] e, logic [63:0] m);
      logic [63:0] r;
      r = 64'd1 % m;
      b = b % m;
      while (e != 0) begin
         if (e[0]) r = mul_m(r, b, m);
         b = mul_m(b, b, m);
         e = e >> 1;
      end
      return r;
   endfunction

   function automatic logic [1:0] euler_kind(logic [63:0] a, logic [63:0] p);
      logic [63:0] r;
      r = pow_m(a, (p - 64'd1) >> 1, p);
      if (r == 0) return msr_pkg::EC_ZERO;
      if (r == 1) return msr_pkg::EC_ONE;
      if (r == p - 64'd1) return msr_pkg::EC_MINUS;
      return msr_pkg::EC_OTHER;
   endfunction

   // real part of (t + sqrt(w))^e in GF(p^2)
   function automatic logic [63:0] ext_real(logic [63:0] t, logic [63:0] w, logic [63:0] e,
                                            logic [63:0] p);
      logic [63:0] rr, ri, br, bi, nr, ni;
      rr = 64'd1 % p;
      ri = 0;
      br = t % p;
      bi = 64'd1 % p;
      while (e != 0) begin
         if (e[0]) begin
            nr = add_m(mul_m(rr, br, p), mul_m(mul_m(ri, bi, p), w, p), p);
            ni = add_m(mul_m(rr, bi, p), mul_m(ri, br, p), p);
            rr = nr;
            ri = ni;
         end
         nr = add_m(mul_m(br, br, p), mul_m(mul_m(bi, bi, p), w, p), p);
         ni = mul_m(add_m(br, br, p), bi, p);
         br = nr;
         bi = ni;
         e = e >> 1;
      end
      return rr;
   endfunction

   function automatic msr_pkg::rsp_type cipolla_roots(msr_pkg::req_type rq);
      msr_pkg::rsp_type r;
      logic [63:0]      p, a, w, x1, x2;
      logic [1:0]       kind;
      logic             ok1, ok2;
      r = '0;
      r.root_count = msr_pkg::CNT_NONE;
      p = rq.modulus;
      if (p <= 64'd2) begin
         r.status = msr_pkg::ST_BADMOD;
         return r;
      end
      a = rq.value % p;
      if (a == 0) begin
         r.root_count = msr_pkg::CNT_ONE;
         r.status = msr_pkg::ST_FOUND;
         return r;
      end
      kind = euler_kind(a, p);
      if (kind == msr_pkg::EC_OTHER) begin
         r.status = msr_pkg::ST_BADMOD;
         return r;
      end
      if (kind != msr_pkg::EC_ONE) begin
         r.status = msr_pkg::ST_NONRES;
         return r;
      end
      for (int t = 1; t <= TRY_LIMIT; t++) begin
         w = add_m(mul_m(64'(t) % p, 64'(t) % p, p), (p - a) % p, p);
         if (w == 0) continue;
         kind = euler_kind(w, p);
         if (kind == msr_pkg::EC_OTHER) begin
            r.status = msr_pkg::ST_BADMOD;
            return r;
         end
         if (kind != msr_pkg::EC_MINUS) continue;
         x1 = ext_real(64'(t), w, (p >> 1) + {63'd0, p[0]}, p);
         x2 = (p - x1) % p;
         ok1 = mul_m(x1, x1, p) == a;
         ok2 = (mul_m(x2, x2, p) == a) && (x1 != x2);
         r.status = msr_pkg::ST_FOUND;
         if (ok1 && ok2) begin
            r.root_first = x1;
            r.root_second = x2;
            r.root_count = msr_pkg::CNT_TWO;
            return r;
         end
         if (ok1 || ok2) begin
            r.root_first = ok1 ? x1 : x2;
            r.root_count = msr_pkg::CNT_ONE;
            return r;
         end
      end
      r.status = msr_pkg::ST_EXHAUSTED;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      found_count = 0;
      nonres_count = 0;
      badmod_count = 0;
      exhausted_count = 0;
   end

   assign pending = roots_due.size();

   always @(posedge clock) begin
      msr_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) roots_due = {roots_due, cipolla_roots(req_data)};
         if (rsp_valid && rsp_ready) begin
            if (roots_due.size() == 0) begin
               report_mismatch("response with no request outstanding, count", 64'd1, 64'd0);
            end else begin
               want = roots_due.pop_front();
               if (rsp_data.root_first != want.root_first)
                  report_mismatch("root_first", rsp_data.root_first, want.root_first);
               if (rsp_data.root_second != want.root_second)
                  report_mismatch("root_second", rsp_data.root_second, want.root_second);
               if (rsp_data.root_count != want.root_count)
                  report_mismatch("root_count", 64'(rsp_data.root_count), 64'(want.root_count));
               if (rsp_data.status != want.status)
                  report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
               case (want.status)
                  msr_pkg::ST_FOUND:  found_count++;
                  msr_pkg::ST_NONRES: nonres_count++;
                  msr_pkg::ST_BADMOD: badmod_count++;
                  default:            exhausted_count++;
               endcase
            end
         end
      end
   end
endmodule

>>> dv/testbench.sv
// testbench: drives requests into modular_square_root and stalls its responses;
// checking lives in msr_scoreboard. Uses msr_pkg and msr_scoreboard.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // worst request: about 7200 multiplies on the serial multiplier
   localparam int WATCHDOG_LIMIT = 2000000;
   localparam int RANDOM_REQUESTS = 280;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   msr_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   msr_pkg::rsp_type rsp_data;

   int fail_count, pending, found_count, nonres_count, badmod_count, exhausted_count;
   int idle_cycles;
   int stall_left;
   bit quiet;    // no idling on either side near the end of the run

   modular_square_root DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   msr_scoreboard u_scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .fail_count     (fail_count),
      .pending        (pending),
      .found_count    (found_count),
      .nonres_count   (nonres_count),
      .badmod_count   (badmod_count),
      .exhausted_count(exhausted_count)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Response side: ready drops in bursts, decided at the falling edge.
   initial begin
      rsp_ready = 1'b0;
      stall_left = 0;
   end
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 4) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: cycles with no handshake on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired at %0t with %0d responses outstanding", $realtime, pending);
         $display("FAILURE");
         $finish;
      end
   end

   // One request: optional idle burst, then hold valid until the handshake.
   task automatic send_request(logic [63:0] value, logic [63:0] modulus);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{value: value, modulus: modulus};
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic bit is_prime(logic [63:0] n);
      if (n < 2) return 0;
      for (logic [63:0] d = 2; d * d <= n; d++)
         if (n % d == 0) return 0;
      return 1;
   endfunction

   // first prime at or above a random odd start below 2^bits, bits kept small so trial division stays cheap
   function automatic logic [63:0] random_prime(int bits);
      logic [63:0] n;
      n = 64'($urandom_range(3, (1 << bits) - 1)) | 64'd1;
      while (!is_prime(n)) n = n + 2;
      return n;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] big_prime();
      case ($urandom_range(0, 4))
         0: return 64'd18446744073709551557;   // largest 64-bit prime
         1: return 64'd2305843009213693951;    // 2^61 - 1
         2: return 64'd4294967291;
         3: return 64'd1000000007;
         default: return 64'd998244353;
      endcase
   endfunction

   // square of r modulo p, so the value is a residue by construction
   function automatic logic [63:0] square_mod(logic [63:0] r, logic [63:0] p);
      logic [127:0] sq;
      sq = {64'd0, r} * {64'd0, r};
      return 64'(sq % {64'd0, p});
   endfunction

   initial begin
      logic [63:0] p, v;
      int pick;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      quiet = 1'b0;
      idle_cycles = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: rejected moduli, zero value, residues, non-residues, composites,
      // even moduli and the field extremes
      send_request(64'd5, 64'd0);
      send_request(64'd5, 64'd1);
      send_request('1, 64'd2);
      send_request(64'd0, 64'd7);
      send_request(64'd14, 64'd7);
      send_request(64'd2, 64'd7);
      send_request(64'd3, 64'd7);
      send_request(64'd1, 64'd3);
      send_request(64'd4, 64'd5);
      send_request(64'd1, 64'd5);
      send_request('1, '1);
      send_request(64'd2, 64'd9);       // composite caught by Euler
      send_request(64'd3, 64'd9);       // Euler result zero
      send_request(64'd4, 64'd8);
      send_request(64'd1, 64'd4);
      send_request(64'd3, 64'd6);
      send_request('1, 64'd18446744073709551557);
      send_request(64'd2, 64'd2305843009213693951);
      send_request(square_mod(64'hFFFF_FFF0, 64'd4294967291), 64'd4294967291);
      send_request(64'd1, 64'd1000000007);
      send_request(64'd0, '1);
      send_request(64'h8000_0000_0000_0000, 64'd998244353);

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i == RANDOM_REQUESTS - 30) quiet = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            p = ($urandom_range(0, 3) == 0) ? big_prime() : random_prime($urandom_range(2, 20));
            case ($urandom_range(0, 3))
               0: v = rand64();
               1: v = rand64() % p;
               default: v = square_mod(rand64() % p, p);  // residue
            endcase
         end else if (pick < 65) begin
            p = 64'($urandom_range(0, 2));
            v = rand64();
         end else if (pick < 80) begin
            p = random_prime(10) * random_prime(10);    // odd composite
            v = ($urandom_range(0, 1) == 0) ? rand64() : square_mod(rand64() % p, p);
         end else if (pick < 88) begin
            p = 64'($urandom_range(2, 5000)) << 1;     // even modulus
            v = rand64();
         end else begin
            p = rand64();
            v = rand64();
         end
         send_request(v, p);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("responses: %0d with roots, %0d non-residue, %0d bad modulus, %0d exhausted",
               found_count, nonres_count, badmod_count, exhausted_count);
      $display("moduli covered: rejected, prime small and 64-bit, composite, even, random");
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
